@@ hw/rtl/akt_pkg.sv @@
// Shared types, field widths and command/status codes for the access key table.
`timescale 1ns / 1ps
package akt_pkg;

  // Field widths of the command and result words
  localparam int CMD_W    = 2;
  localparam int CODE_W   = 32;
  localparam int KIND_W   = 2;
  localparam int IDX_W    = 6;
  localparam int STATUS_W = 3;
  localparam int HIT_W    = 6;
  localparam int USED_W   = 7;
  localparam int KEY_W    = CODE_W + KIND_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_CHECK  = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_DELETE = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_FULL      = 3'd3,
    ST_BAD_INDEX = 3'd4
  } status_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    load;        // capture the incoming word
    logic    scan_init;   // restart the walk at entry 0
    logic    shift_init;  // restart the walk one past pos
    logic    step;        // issue the next read of the walk
    logic    shift_wr;    // walk moves entries down one place
    logic    capture;     // latch the matching address as pos
    logic    append;      // write key at the end, bump the count
    logic    dec;         // drop the count after a compaction
    logic    post;        // load the result register
    status_t status;
  } akt_ctl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    cmd_t cmd;
    logic match;     // registered read data equals the key
    logic walk_end;  // no read left to issue and none in flight
    logic idx_ok;    // delete index below the count
    logic full;
  } akt_sts_t;

endpackage

@@ hw/rtl/akt_if.sv @@
// Valid/ready channel interfaces for command words and result words.
`timescale 1ns / 1ps
interface akt_in_if;
  logic                          valid;
  logic                          ready;
  logic [akt_pkg::CMD_W-1:0]     cmd;
  logic [akt_pkg::CODE_W-1:0]    key_code;
  logic [akt_pkg::KIND_W-1:0]    key_kind;
  logic [akt_pkg::IDX_W-1:0]     entry_index;

  modport source (output valid, cmd, key_code, key_kind, entry_index, input ready);
  modport sink   (input valid, cmd, key_code, key_kind, entry_index, output ready);
endinterface

interface akt_out_if;
  logic                          valid;
  logic                          ready;
  logic [akt_pkg::STATUS_W-1:0]  status;
  logic [akt_pkg::HIT_W-1:0]     hit_index;
  logic [akt_pkg::USED_W-1:0]    entries_used;

  modport source (output valid, status, hit_index, entries_used, input ready);
  modport sink   (input valid, status, hit_index, entries_used, output ready);
endinterface

@@ hw/rtl/access_key_table.sv @@
// Access key table: packed credential key store with check/add/remove/delete.
// Operation: check/add walk the store from entry 0 to a match or the end; remove
//   adds a compaction pass from the matched position, and delete runs the
//   compaction pass from its index with no lookup walk.
// Throughput: one command word at a time, bound by the walk of the key store
//   (one entry read per cycle, reads and shift writes overlapped).
// Reset: entry count and handshake state clear; store contents are not cleared.
`timescale 1ns / 1ps
module access_key_table #(
  parameter int TABLE_DEPTH = 64
) (
  input logic       clk,
  input logic       rst_n,
  akt_in_if.sink    in_chan,
  akt_out_if.source out_chan
);
  import akt_pkg::*;

  akt_ctl_t ctl;
  akt_sts_t sts;

  akt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  akt_dp #(
    .DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_cmd           (in_chan.cmd),
    .in_key_code      (in_chan.key_code),
    .in_key_kind      (in_chan.key_kind),
    .in_entry_index   (in_chan.entry_index),
    .ctl              (ctl),
    .sts              (sts),
    .out_status       (out_chan.status),
    .out_hit_index    (out_chan.hit_index),
    .out_entries_used (out_chan.entries_used)
  );

endmodule

@@ hw/rtl/akt_dp.sv @@
// Datapath: key store memory, count, walk pointer and result register.
`timescale 1ns / 1ps
module akt_dp #(
  parameter int DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [akt_pkg::CMD_W-1:0]     in_cmd,
  input  logic [akt_pkg::CODE_W-1:0]    in_key_code,
  input  logic [akt_pkg::KIND_W-1:0]    in_key_kind,
  input  logic [akt_pkg::IDX_W-1:0]     in_entry_index,
  input  akt_pkg::akt_ctl_t             ctl,
  output akt_pkg::akt_sts_t             sts,
  output logic [akt_pkg::STATUS_W-1:0]  out_status,
  output logic [akt_pkg::HIT_W-1:0]     out_hit_index,
  output logic [akt_pkg::USED_W-1:0]    out_entries_used
);
  import akt_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (CW > IDX_W) ? CW : IDX_W;

  logic [KEY_W-1:0] mem [DEPTH];

  cmd_t             cmd_r;
  logic [KEY_W-1:0] key_r;
  logic [IDX_W-1:0] idx_r;
  logic [CW-1:0]    cnt_r;
  logic [CW-1:0]    ptr_r;
  logic [CW-1:0]    pos_r;
  logic             rv_r;
  logic [AW-1:0]    rd_addr_r;
  logic [KEY_W-1:0] rd_data_r;
  status_t          out_status_r;
  logic [HIT_W-1:0] out_hit_r;
  logic [USED_W-1:0] out_used_r;

  logic             rd_en;
  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  logic [KEY_W-1:0] mem_wd;

  // Walk read, append write and compaction write
  assign rd_en  = ctl.step && (ptr_r < cnt_r);
  assign mem_we = ctl.append || (ctl.step && ctl.shift_wr && rv_r);
  assign mem_wa = ctl.append ? AW'(cnt_r) : (rd_addr_r - AW'(1));
  assign mem_wd = ctl.append ? key_r : rd_data_r;

  // Status back to the controller
  assign sts.cmd      = cmd_r;
  assign sts.match    = rv_r && (rd_data_r == key_r);
  assign sts.walk_end = !rv_r && (ptr_r >= cnt_r);
  assign sts.idx_ok   = IW'(idx_r) < IW'(cnt_r);
  assign sts.full     = (cnt_r == CW'(DEPTH));

  // Key store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_data_r <= mem[AW'(ptr_r)];
      rd_addr_r <= AW'(ptr_r);
    end
  end

  // Control state: count, walk pointer, read-in-flight flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ptr_r <= '0;
      rv_r  <= 1'b0;
    end else begin
      if (ctl.append) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (ctl.dec) begin
        cnt_r <= cnt_r - CW'(1);
      end
      if (ctl.scan_init) begin
        ptr_r <= '0;
      end else if (ctl.shift_init) begin
        ptr_r <= pos_r + CW'(1);
      end else if (rd_en) begin
        ptr_r <= ptr_r + CW'(1);
      end
      rv_r <= ctl.step && rd_en;
    end
  end

  // Command word, position and result register
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= cmd_t'(in_cmd);
      key_r <= {in_key_kind, in_key_code};
      idx_r <= in_entry_index;
      pos_r <= CW'(in_entry_index);
    end else if (ctl.capture) begin
      pos_r <= CW'(rd_addr_r);
    end else if (ctl.append) begin
      pos_r <= cnt_r;
    end
    if (ctl.post) begin
      out_status_r <= ctl.status;
      out_hit_r    <= (ctl.status == ST_OK) ? HIT_W'(pos_r) : '0;
      out_used_r   <= USED_W'(cnt_r);
    end
  end

  assign out_status       = out_status_r;
  assign out_hit_index    = out_hit_r;
  assign out_entries_used = out_used_r;

  // Checks
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("entry count beyond table depth");
  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.append |-> (cnt_r < CW'(DEPTH)))
    else $error("append into a full table");
  a_shift_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.step && ctl.shift_wr && rv_r) |-> (rd_addr_r != '0))
    else $error("compaction write below entry 0");
  a_dec_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.dec |-> (cnt_r != '0))
    else $error("count decrement at zero");

endmodule

@@ hw/rtl/akt_ctrl.sv @@
// Controller: sequences decode, table walk, compaction and result posting.
`timescale 1ns / 1ps
module akt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  akt_pkg::akt_sts_t sts,
  output akt_pkg::akt_ctl_t ctl
);
  import akt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_SHIFT_INIT,
    S_SHIFT,
    S_POST
  } state_t;

  state_t  state_r, state_nxt;
  status_t st_r, st_nxt;
  logic    out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ctl           = '0;
    ctl.status    = st_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.cmd == CMD_DELETE) begin
          if (sts.idx_ok) begin
            st_nxt    = ST_OK;
            state_nxt = S_SHIFT_INIT;
          end else begin
            st_nxt    = ST_BAD_INDEX;
            state_nxt = S_POST;
          end
        end else begin
          ctl.scan_init = 1'b1;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.match) begin
          ctl.capture = 1'b1;
          unique case (sts.cmd)
            CMD_CHECK: begin
              st_nxt    = ST_OK;
              state_nxt = S_POST;
            end
            CMD_ADD: begin
              st_nxt    = ST_DUPLICATE;
              state_nxt = S_POST;
            end
            CMD_REMOVE: begin
              st_nxt    = ST_OK;
              state_nxt = S_SHIFT_INIT;
            end
            CMD_DELETE: begin
              st_nxt    = ST_BAD_INDEX;
              state_nxt = S_POST;
            end
          endcase
        end else if (sts.walk_end) begin
          state_nxt = S_POST;
          if (sts.cmd != CMD_ADD) begin
            st_nxt = ST_NOT_FOUND;
          end else if (sts.full) begin
            st_nxt = ST_FULL;
          end else begin
            ctl.append = 1'b1;
            st_nxt     = ST_OK;
          end
        end else begin
          ctl.step = 1'b1;
        end
      end
      S_SHIFT_INIT: begin
        ctl.shift_init = 1'b1;
        state_nxt      = S_SHIFT;
      end
      S_SHIFT: begin
        if (sts.walk_end) begin
          ctl.dec   = 1'b1;
          state_nxt = S_POST;
        end else begin
          ctl.step     = 1'b1;
          ctl.shift_wr = 1'b1;
        end
      end
      S_POST: begin
        // wait for the result slot to drain
        if (!out_valid_r || out_ready) begin
          ctl.post      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      st_r        <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Checks
  a_post_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.post |-> (!out_valid_r || out_ready))
    else $error("result posted over an untaken word");
  a_post_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.post |=> out_valid_r)
    else $error("posted result not presented");
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |=> !in_ready)
    else $error("command accepted while busy");

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the access key table: random and directed command words.
`timescale 1ns / 1ps
module tb;
  import akt_pkg::*;

  localparam int DEPTH     = 64;
  localparam int WDOG_MAX  = 4000;  // idle cycles before the run is declared hung
  localparam int DRAIN     = 200;   // covers a full-table delete plus compaction
  localparam int PER_PHASE = 207;

  // One expected result word
  typedef struct {
    status_t          st;
    bit [HIT_W-1:0]   hit;
    bit [USED_W-1:0]  used;
  } akt_result_t;

  // Tracks table contents, predicts results and checks them in order
  class key_table_board;
    bit [KEY_W-1:0] slots[DEPTH];
    int unsigned    used;
    akt_result_t    pending_q[$];
    int             errors;
    int             n_words;
    int             n_results;
    int             n_full;
    int             st_count[5];

    function int unsigned find_key(bit [KEY_W-1:0] key);
      for (int unsigned i = 0; i < used; i++) begin
        if (slots[i] == key) return i;
      end
      return used;
    endfunction

    // Close the gap at pos by moving later entries down
    function void drop_at(int unsigned pos);
      for (int unsigned i = pos; i + 1 < used; i++) slots[i] = slots[i + 1];
      used--;
    endfunction

    function void note_word(cmd_t c, bit [CODE_W-1:0] code, bit [KIND_W-1:0] kind,
                            bit [IDX_W-1:0] idx);
      bit [KEY_W-1:0] key;
      int unsigned    pos;
      akt_result_t    r;
      key   = {kind, code};
      r.st  = ST_OK;
      r.hit = '0;
      case (c)
        CMD_CHECK: begin
          pos = find_key(key);
          if (pos < used) r.hit = pos[HIT_W-1:0];
          else r.st = ST_NOT_FOUND;
        end
        CMD_ADD: begin
          pos = find_key(key);
          if (pos < used) begin
            r.st = ST_DUPLICATE;
          end else if (used >= DEPTH) begin
            r.st = ST_FULL;
            n_full++;
          end else begin
            slots[used] = key;
            r.hit = used[HIT_W-1:0];
            used++;
          end
        end
        CMD_REMOVE: begin
          pos = find_key(key);
          if (pos < used) begin
            r.hit = pos[HIT_W-1:0];
            drop_at(pos);
          end else begin
            r.st = ST_NOT_FOUND;
          end
        end
        default: begin
          if (idx < used) begin
            r.hit = idx;
            drop_at(idx);
          end else begin
            r.st = ST_BAD_INDEX;
          end
        end
      endcase
      r.used = used[USED_W-1:0];
      st_count[r.st]++;
      n_words++;
      pending_q.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 20) $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task check_word(logic [STATUS_W-1:0] st, logic [HIT_W-1:0] hit,
                    logic [USED_W-1:0] n);
      akt_result_t r;
      if (pending_q.size() == 0) begin
        report($sformatf("result word with nothing pending (st=%0d hit=%0d used=%0d)",
                         st, hit, n));
      end else begin
        r = pending_q.pop_front();
        n_results++;
        if (st !== r.st)
          report($sformatf("result %0d status %0d, want %0d", n_results, st, r.st));
        if (hit !== r.hit)
          report($sformatf("result %0d hit_index %0d, want %0d", n_results, hit, r.hit));
        if (n !== r.used)
          report($sformatf("result %0d entries_used %0d, want %0d", n_results, n, r.used));
      end
    endtask

    function int pending();
      return pending_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   gap_pct;
  int   stall_pct;
  int   idle_cycles;
  bit   grow;

  key_table_board board = new();

  akt_in_if  in_chan();
  akt_out_if out_chan();

  access_key_table #(.TABLE_DEPTH(DEPTH)) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Clock, 12 ns period
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result side: check accepted words, then pick next ready
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_chan.ready <= 1'b0;
      end else begin
        if (out_chan.valid && out_chan.ready)
          board.check_word(out_chan.status, out_chan.hit_index, out_chan.entries_used);
        out_chan.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
        $display("watchdog: no handshake for %0d cycles", WDOG_MAX);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Present one command word and hold it until accepted
  task automatic send_word(cmd_t c, bit [CODE_W-1:0] code, bit [KIND_W-1:0] kind,
                           bit [IDX_W-1:0] idx);
    if ($urandom_range(99) < gap_pct) begin
      in_chan.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_chan.valid       <= 1'b1;
    in_chan.cmd         <= c;
    in_chan.key_code    <= code;
    in_chan.key_kind    <= kind;
    in_chan.entry_index <= idx;
    do @(posedge clk); while (!in_chan.ready);
    board.note_word(c, code, kind, idx);
  endtask

  // Key choice: often a stored one, sometimes a near miss, else fresh
  task automatic pick_key(int pct_stored, output bit [CODE_W-1:0] code,
                          output bit [KIND_W-1:0] kind);
    bit [KEY_W-1:0] k;
    int             r;
    r = $urandom_range(99);
    if (board.used > 0 && r < pct_stored + 20) begin
      k    = board.slots[$urandom_range(board.used - 1)];
      code = k[CODE_W-1:0];
      kind = k[KEY_W-1:CODE_W];
      if (r >= pct_stored + 10) code[$urandom_range(CODE_W - 1)] ^= 1'b1;
      else if (r >= pct_stored) kind ^= 2'($urandom_range(1, 3));
    end else begin
      code = $urandom;
      kind = KIND_W'($urandom_range(3));
    end
  endtask

  // One random command; alternates between filling and draining the table
  task automatic random_word();
    bit [CODE_W-1:0] code;
    bit [KIND_W-1:0] kind;
    bit [IDX_W-1:0]  idx;
    int              r;
    cmd_t            c;
    if (grow && board.used == DEPTH && $urandom_range(3) == 0) grow = 0;
    else if (!grow && (board.used == 0 || (board.used < 6 && $urandom_range(3) == 0)))
      grow = 1;
    r = $urandom_range(99);
    if (grow) c = (r < 55) ? CMD_ADD : (r < 75) ? CMD_CHECK : (r < 85) ? CMD_REMOVE : CMD_DELETE;
    else c = (r < 10) ? CMD_ADD : (r < 30) ? CMD_CHECK : (r < 65) ? CMD_REMOVE : CMD_DELETE;
    pick_key((c == CMD_ADD) ? 10 : 55, code, kind);
    if (board.used > 0 && $urandom_range(99) < 70) idx = IDX_W'($urandom_range(board.used - 1));
    else idx = IDX_W'($urandom_range(DEPTH - 1));
    send_word(c, code, kind, idx);
  endtask

  initial begin
    // Known values on every input from time zero
    rst_n                <= 1'b0;
    in_chan.valid        <= 1'b0;
    in_chan.cmd          <= CMD_CHECK;
    in_chan.key_code     <= '0;
    in_chan.key_kind     <= '0;
    in_chan.entry_index  <= '0;
    gap_pct   = 0;
    stall_pct = 0;
    grow      = 1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, extreme codes and kinds, duplicates, edge indexes
    send_word(CMD_CHECK,  32'h0000_0000, 2'd0, IDX_W'($urandom));
    send_word(CMD_REMOVE, 32'hFFFF_FFFF, 2'd3, IDX_W'($urandom));
    send_word(CMD_DELETE, $urandom, KIND_W'($urandom), 6'd0);
    send_word(CMD_DELETE, $urandom, KIND_W'($urandom), 6'd63);
    send_word(CMD_ADD,    32'h0000_0000, 2'd0, IDX_W'($urandom));
    send_word(CMD_ADD,    32'hFFFF_FFFF, 2'd3, IDX_W'($urandom));
    send_word(CMD_ADD,    32'hFFFF_FFFF, 2'd0, IDX_W'($urandom));
    send_word(CMD_ADD,    32'h1234_5678, 2'd1, IDX_W'($urandom));
    send_word(CMD_ADD,    32'hA5A5_A5A5, 2'd2, IDX_W'($urandom));
    send_word(CMD_ADD,    32'h0000_0000, 2'd0, IDX_W'($urandom));
    send_word(CMD_ADD,    32'hFFFF_FFFF, 2'd2, IDX_W'($urandom));
    send_word(CMD_CHECK,  32'hFFFF_FFFF, 2'd0, IDX_W'($urandom));
    send_word(CMD_CHECK,  32'hFFFF_FFFF, 2'd1, IDX_W'($urandom));
    send_word(CMD_CHECK,  32'h0000_0000, 2'd0, IDX_W'($urandom));
    send_word(CMD_REMOVE, 32'hFFFF_FFFF, 2'd3, IDX_W'($urandom));
    send_word(CMD_DELETE, $urandom, KIND_W'($urandom), 6'd4);
    send_word(CMD_DELETE, $urandom, KIND_W'($urandom), 6'd4);
    send_word(CMD_DELETE, $urandom, KIND_W'($urandom), 6'd0);
    send_word(CMD_CHECK,  32'h1234_5678, 2'd1, IDX_W'($urandom));
    send_word(CMD_REMOVE, 32'h1234_5678, 2'd1, IDX_W'($urandom));
    send_word(CMD_REMOVE, 32'h1234_5678, 2'd1, IDX_W'($urandom));
    send_word(CMD_ADD,    32'h5A5A_5A5A, 2'd1, IDX_W'($urandom));

    // Random: no idling, sender gaps, receiver stalls, light mix of both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 66; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 66; end
        default: begin gap_pct = 10; stall_pct = 10; end
      endcase
      for (int i = 0; i < PER_PHASE; i++) random_word();
    end
    in_chan.valid <= 1'b0;

    // Wait for outstanding results, then let the block settle
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("%0d command words, %0d results checked, %0d adds hit a full table",
             board.n_words, board.n_results, board.n_full);
    $display("status mix: ok %0d, not found %0d, duplicate %0d, full %0d, bad index %0d",
             board.st_count[0], board.st_count[1], board.st_count[2],
             board.st_count[3], board.st_count[4]);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/akt_pkg.sv
hw/rtl/akt_if.sv
hw/rtl/akt_dp.sv
hw/rtl/akt_ctrl.sv
hw/rtl/access_key_table.sv
tb/tb.sv
